### design/fprc_pkg.sv
// Shared constants, payload types and line-tracking state for the finder pattern check.
// No dependencies; every other file in the project depends on this package.
package fprc_pkg;

    localparam int LINE_WIDTH_MAX = 2048;
    localparam int POS_W          = $clog2(LINE_WIDTH_MAX);
    localparam int RUN_W          = $clog2(LINE_WIDTH_MAX) + 1;
    localparam int PIXEL_W        = 8;
    localparam int BOUND_W        = 6;
    localparam int PROD_W         = BOUND_W + RUN_W;
    localparam int CFG_IDX_W      = 1;

    localparam int RATIO_SCALE      = 30;
    localparam int MIN_RUNS         = 5;
    localparam int SIDE_RUNS_NEEDED = 2;

    localparam logic [BOUND_W-1:0] RATIO_LOW_RESET  = BOUND_W'(6);
    localparam logic [BOUND_W-1:0] RATIO_HIGH_RESET = BOUND_W'(19);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATIO_LOW  = 1'b0,
        REG_RATIO_HIGH = 1'b1
    } t_cfg_reg;

    typedef logic [RUN_W-1:0] t_run;
    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               line_end;
    } t_pix;

    typedef struct packed {
        logic is_finder;
        t_run longest_run;
        t_pos longest_start;
    } t_res;

    // Per-line run tracking state.
    typedef struct packed {
        logic      started;
        logic      prev_color;
        t_run      run_length;
        t_pos      pos;
        t_pos      run_start;
        t_run [1:0] recent;
        t_run      runs_seen;
        t_run      best_run;
        t_pos      best_start;
        t_run      best_index;
        t_run [1:0] prior;
        t_run [1:0] after;
    } t_line;

    // Closed line captured for the ratio test.
    typedef struct packed {
        logic       counts_ok;
        t_run       best_run;
        t_pos       best_start;
        t_run [3:0] side;
    } t_eval;

endpackage

### design/fprc_pix_if.sv
// Pixel input channel: valid/ready handshake with one pixel and its line-end flag.
// Depends on fprc_pkg for the payload type.
interface fprc_pix_if;
    logic          valid;
    logic          ready;
    fprc_pkg::t_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/fprc_res_if.sv
// Result output channel: valid/ready handshake with one finder pattern verdict per line.
// Depends on fprc_pkg for the payload type.
interface fprc_res_if;
    logic          valid;
    logic          ready;
    fprc_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/finder_pattern_ratio_check_core.sv
// Top level of the 1:1:3:1:1 finder pattern run ratio check along one scan line.
// Depends on fprc_pkg and the interfaces fprc_pix_if and fprc_res_if.
//
//  Channel   Direction  Handshake        Payload
//  i_pix     in         valid / ready    pixel[7:0], line_end
//  o_res     out        valid / ready    is_finder, longest_run[11:0], longest_start[10:0]
//  i_cfg_*   in         write enable     index 0 ratio_low_thirtieths, 1 ratio_high_thirtieths
//
// One pixel transaction is accepted every clock cycle while no line-end pixel waits in the input
// register for room downstream. A pixel passes through the input register, then the run tracker
// updates its line state from it; a line end also loads the evaluation register, and the ratio
// multiply-compare moves the captured line on into the result register.
// Reset (i_rst_n low, synchronous) empties all stages, clears the line state and restores the
// default ratio bounds. A stalled result only holds back line-end pixels once the evaluation
// register is also full; ordinary pixels keep flowing into the run tracker.
module finder_pattern_ratio_check_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    fprc_pix_if.sink                           i_pix,
    fprc_res_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [fprc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fprc_pkg::BOUND_W-1:0]       i_cfg_data
);
    import fprc_pkg::*;

    localparam t_pos POS_LAST = POS_W'(LINE_WIDTH_MAX - 1);

    // Configuration registers.
    logic [BOUND_W-1:0] r_ratio_low;
    logic [BOUND_W-1:0] r_ratio_high;

    // Pipeline registers and their valid flags.
    logic  r_in_valid;
    t_pix  r_in;
    t_line r_st;
    t_line n_st;
    logic  r_ev_valid;
    t_eval r_ev;
    t_eval n_ev;
    logic  r_res_valid;
    t_res  r_res;
    t_res  n_res;

    // Flow control.
    logic res_load;
    logic ev_move;
    logic ev_free;
    logic in_move;
    logic in_take;

    // A run has ended: it may become the new longest run, or fill one of the two slots that
    // follow the longest run. The completed-run count saturates at the line width limit.
    function automatic t_line close_run(input t_line s);
        t_line o;
        o = s;
        if (s.run_length > s.best_run) begin
            o.best_run   = s.run_length;
            o.best_start = s.run_start;
            o.best_index = s.runs_seen;
            o.prior      = s.recent;
            o.after      = '0;
        end else if (s.runs_seen == RUN_W'(s.best_index + 1'b1)) begin
            o.after[0] = s.run_length;
        end else if (s.runs_seen == RUN_W'(s.best_index + 2'd2)) begin
            o.after[1] = s.run_length;
        end
        o.recent[0] = s.recent[1];
        o.recent[1] = s.run_length;
        if (s.runs_seen < RUN_W'(LINE_WIDTH_MAX)) begin
            o.runs_seen = RUN_W'(s.runs_seen + 1'b1);
        end
        return o;
    endfunction

    // A side run passes when low * longest < 30 * run < high * longest.
    function automatic logic side_ok(input t_run r, input logic [PROD_W-1:0] lo,
                                     input logic [PROD_W-1:0] hi);
        logic [PROD_W-1:0] scaled;
        scaled = PROD_W'(r) * PROD_W'(RATIO_SCALE);
        return (scaled > lo) && (scaled < hi);
    endfunction

    assign res_load = !r_res_valid || o_res.ready;
    assign ev_move  = r_ev_valid && res_load;
    assign ev_free  = !r_ev_valid || res_load;
    // Only a line-end pixel needs room downstream; other pixels only touch the line state.
    assign in_move  = r_in_valid && (!r_in.line_end || ev_free);
    assign in_take  = i_pix.valid && i_pix.ready;

    assign i_pix.ready = !r_in_valid || in_move;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    // Run tracking for the pixel in the input register.
    always_comb begin
        t_line st;
        t_line fin;
        logic  color;
        st    = r_st;
        color = |r_in.pixel;
        if (!st.started) begin
            // First pixel of a line opens its first run on cleared state.
            st            = '0;
            st.started    = 1'b1;
            st.prev_color = color;
            st.run_length = RUN_W'(1);
        end else if (st.pos != POS_LAST) begin
            st.pos = POS_W'(st.pos + 1'b1);
            if (color != st.prev_color) begin
                st            = close_run(st);
                st.run_start  = st.pos;
                st.run_length = RUN_W'(1);
                st.prev_color = color;
            end else begin
                st.run_length = RUN_W'(st.run_length + 1'b1);
            end
        end
        // Pixels past the line width limit fall through unchanged; their line end still counts.
        fin = close_run(st);

        n_ev.best_run   = fin.best_run;
        n_ev.best_start = fin.best_start;
        n_ev.side[0]    = fin.prior[0];
        n_ev.side[1]    = fin.prior[1];
        n_ev.side[2]    = fin.after[0];
        n_ev.side[3]    = fin.after[1];
        n_ev.counts_ok  = (fin.runs_seen >= RUN_W'(MIN_RUNS)) &&
                          (fin.best_index >= RUN_W'(SIDE_RUNS_NEEDED)) &&
                          ({1'b0, fin.runs_seen} >=
                           ({1'b0, fin.best_index} + (RUN_W+1)'(SIDE_RUNS_NEEDED + 1)));

        // After a line end the state is left cleared with no line open.
        n_st = r_in.line_end ? '0 : st;
    end

    // Ratio test on the captured line.
    always_comb begin
        logic [PROD_W-1:0] lo;
        logic [PROD_W-1:0] hi;
        lo = PROD_W'(r_ratio_low)  * PROD_W'(r_ev.best_run);
        hi = PROD_W'(r_ratio_high) * PROD_W'(r_ev.best_run);
        n_res.is_finder     = r_ev.counts_ok &&
                              side_ok(r_ev.side[0], lo, hi) && side_ok(r_ev.side[1], lo, hi) &&
                              side_ok(r_ev.side[2], lo, hi) && side_ok(r_ev.side[3], lo, hi);
        n_res.longest_run   = r_ev.best_run;
        n_res.longest_start = r_ev.best_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_low  <= RATIO_LOW_RESET;
            r_ratio_high <= RATIO_HIGH_RESET;
            r_in_valid   <= 1'b0;
            r_st         <= '0;
            r_ev_valid   <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_RATIO_LOW:  r_ratio_low  <= i_cfg_data;
                    REG_RATIO_HIGH: r_ratio_high <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (in_move) begin
                r_in_valid <= 1'b0;
            end

            if (in_move) begin
                r_st <= n_st;
            end

            if (in_move && r_in.line_end) begin
                r_ev_valid <= 1'b1;
            end else if (ev_move) begin
                r_ev_valid <= 1'b0;
            end

            if (ev_move) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_pix.data;
        end
        if (in_move && r_in.line_end) begin
            r_ev <= n_ev;
        end
        if (ev_move) begin
            r_res <= n_res;
        end
    end

endmodule
